// ===== src/tone_grade_pixel_filter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Tone grade pixel filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef TONE_GRADE_PIXEL_FILTER_TOP_ASSERT_SVH
`define TONE_GRADE_PIXEL_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tgpf_pkg.sv =====
// ----------------------------------------------------------------------------
// Tone grade pixel filter package
// Shared types, constants and the per-tone term table.
// ----------------------------------------------------------------------------
package tgpf_pkg;

  // Configuration register indexes.
  localparam logic [3:0] CFG_TONE_MODE = 4'd0;
  localparam logic [3:0] CFG_STRENGTH  = 4'd1;

  // Channel indexes used by the back end.
  localparam logic [1:0] CH_RED = 2'd0;
  localparam logic [1:0] CH_GRN = 2'd1;
  localparam logic [1:0] CH_BLU = 2'd2;

  // Weight codes with 8 fraction bits.
  localparam logic [8:0] K005 = 9'd13;
  localparam logic [8:0] K01  = 9'd26;
  localparam logic [8:0] K015 = 9'd38;
  localparam logic [8:0] K02  = 9'd51;
  localparam logic [8:0] K03  = 9'd77;
  localparam logic [8:0] K04  = 9'd102;
  localparam logic [8:0] K05  = 9'd128;
  localparam logic [8:0] K06  = 9'd154;
  localparam logic [8:0] K07  = 9'd179;
  localparam logic [8:0] K08  = 9'd205;
  localparam logic [8:0] K09  = 9'd230;
  localparam logic [8:0] K1   = 9'd256;

  typedef enum logic [4:0] {
    TONE_SOFT, TONE_INTENSE, TONE_WARM, TONE_COLD, TONE_PASTEL, TONE_MUTED,
    TONE_VIBRANT, TONE_ROUGH, TONE_GOLDEN, TONE_NOIR, TONE_NEON, TONE_DREAM,
    TONE_SUNSET, TONE_OCEAN, TONE_FOREST, TONE_TWILIGHT, TONE_EMBER,
    TONE_FROST, TONE_HAZE, TONE_CANDY, TONE_LAVA, TONE_ALIEN, TONE_VINTAGE,
    TONE_CYBER
  } tone_e;

  // Left operand of a term difference.
  typedef enum logic [3:0] {
    A_ZERO, A_C, A_R, A_G, A_B, A_Y, A_LV, A_SR, A_SG, A_SB, A_VIB, A_NOISE,
    A_CYB
  } opa_e;

  // Right operand of a term difference.
  typedef enum logic [2:0] {
    B_ZERO, B_C, B_R, B_G, B_B, B_Y, B_L128, B_SB
  } opb_e;

  // One scaled term: (a - b) * k * factor / 2^24, added or subtracted.
  typedef struct packed {
    opa_e        a;
    logic [7:0]  av;
    opb_e        b;
    logic [8:0]  k;
    logic        neg;
    logic        inv;
  } term_t;

  // One pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [15:0]       luma;
    logic signed [6:0] noise;
    logic [4:0]        mode;
  } tgpf_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } tgpf_qstat_t;

  function automatic term_t mk(opa_e a, logic [7:0] av, opb_e b, logic [8:0] k);
    term_t t;
    t.a   = a;
    t.av  = av;
    t.b   = b;
    t.k   = k;
    t.neg = 1'b0;
    t.inv = 1'b0;
    return t;
  endfunction

  // Subtracted term of the own channel alone.
  function automatic term_t mkn(logic [8:0] k);
    term_t t;
    t     = mk(A_C, 8'd0, B_ZERO, k);
    t.neg = 1'b1;
    return t;
  endfunction

  // Returns term idx of channel ch for tone mode. Unused slots weigh zero.
  function automatic term_t tone_term(logic [4:0] mode, logic [1:0] ch,
                                      logic [1:0] idx);
    term_t z;
    term_t t0;
    term_t t1;
    term_t t2;
    term_t res;
    z  = mk(A_ZERO, 8'd0, B_ZERO, 9'd0);
    t0 = z;
    t1 = z;
    t2 = z;
    unique case (mode)
      TONE_SOFT: begin
        t0 = mk(A_Y, 8'd0, B_C, K05);
        t1 = mk(A_LV, 8'd128, B_C, K03);
      end
      TONE_INTENSE: begin
        t0 = mk(A_C, 8'd0, B_Y, K08);
        t1 = mk(A_C, 8'd0, B_L128, K06);
      end
      TONE_WARM: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K04);
            t1 = mk(A_C, 8'd0, B_Y, K02);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd255, B_C, K015);
            t1 = mk(A_Y, 8'd0, B_C, K01);
          end
          default: begin
            t0 = mkn(K05);
            t1 = mk(A_Y, 8'd0, B_C, K02);
          end
        endcase
      end
      TONE_COLD: begin
        case (ch)
          CH_RED: begin
            t0 = mkn(K05);
            t1 = mk(A_Y, 8'd0, B_C, K02);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd255, B_C, K015);
            t1 = mk(A_Y, 8'd0, B_C, K01);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K04);
            t1 = mk(A_C, 8'd0, B_Y, K02);
          end
        endcase
      end
      TONE_PASTEL: begin
        t0 = mk(A_LV, 8'd255, B_C, K07);
        t1 = mk(A_Y, 8'd0, B_C, K02);
      end
      TONE_MUTED: begin
        t0 = mk(A_Y, 8'd0, B_C, K09);
      end
      TONE_VIBRANT: begin
        t0 = mk(A_VIB, 8'd0, B_C, K07);
        t1 = mk(A_C, 8'd0, B_Y, K05);
      end
      TONE_ROUGH: begin
        t0 = mk(A_NOISE, 8'd0, B_ZERO, K1);
        t1 = mk(A_C, 8'd0, B_Y, K03);
      end
      TONE_GOLDEN: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K05);
            t1 = mk(A_C, 8'd0, B_B, K03);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd215, B_C, K04);
            t1 = mk(A_C, 8'd128, B_SB, K03);
          end
          default: begin
            t0 = mkn(K06);
            t1 = mk(A_SR, 8'd51, B_C, K03);
          end
        endcase
      end
      TONE_NOIR: begin
        t0     = mk(A_C, 8'd0, B_Y, K1);
        t0.inv = 1'b1;
        t1     = mk(A_Y, 8'd0, B_L128, K04);
      end
      TONE_NEON: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K08);
            t1 = mk(A_C, 8'd0, B_Y, K06);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd255, B_C, K03);
            t1 = mk(A_C, 8'd0, B_B, K05);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K08);
            t1 = mk(A_C, 8'd0, B_R, K05);
          end
        endcase
      end
      TONE_DREAM: begin
        t0 = mk(A_LV, 8'd255, B_C, K04);
        case (ch)
          CH_RED: begin
            t1 = mk(A_G, 8'd0, B_C, K03);
            t2 = mk(A_B, 8'd0, B_C, K02);
          end
          CH_GRN: begin
            t1 = mk(A_R, 8'd0, B_C, K03);
            t2 = mk(A_B, 8'd0, B_C, K02);
          end
          default: begin
            t1 = mk(A_R, 8'd0, B_C, K03);
            t2 = mk(A_G, 8'd0, B_C, K02);
          end
        endcase
      end
      TONE_SUNSET: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K06);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd140, B_C, K05);
            t1 = mk(A_R, 8'd0, B_C, K03);
          end
          default: begin
            t0 = mk(A_LV, 8'd180, B_C, K04);
            t1 = mkn(K03);
          end
        endcase
      end
      TONE_OCEAN: begin
        case (ch)
          CH_RED: begin
            t0 = mkn(K05);
            t1 = mk(A_SB, 8'd51, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd180, B_C, K04);
            t1 = mk(A_B, 8'd0, B_C, K03);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K05);
            t1 = mk(A_C, 8'd0, B_R, K03);
          end
        endcase
      end
      TONE_FOREST: begin
        case (ch)
          CH_RED: begin
            t0 = mkn(K05);
            t1 = mk(A_SG, 8'd26, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd200, B_C, K04);
            t1 = mk(A_C, 8'd0, B_R, K03);
            t2 = mk(A_C, 8'd0, B_B, K02);
          end
          default: begin
            t0 = mkn(K04);
            t1 = mk(A_SG, 8'd26, B_C, K02);
          end
        endcase
      end
      TONE_TWILIGHT: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd100, B_C, K05);
            t1 = mk(A_B, 8'd0, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd80, B_C, K04);
            t1 = mk(A_SB, 8'd77, B_C, K02);
          end
          default: begin
            t0 = mk(A_LV, 8'd180, B_C, K05);
            t1 = mk(A_C, 8'd0, B_R, K03);
          end
        endcase
      end
      TONE_EMBER: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K07);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd100, B_C, K05);
            t1 = mk(A_SR, 8'd77, B_C, K03);
          end
          default: begin
            t0 = mkn(K07);
            t1 = mk(A_SR, 8'd13, B_C, K02);
          end
        endcase
      end
      TONE_FROST: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd220, B_C, K04);
            t1 = mk(A_B, 8'd0, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd230, B_C, K04);
            t1 = mk(A_B, 8'd0, B_C, K03);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K05);
          end
        endcase
      end
      TONE_HAZE: begin
        t0 = mk(A_LV, 8'd200, B_C, K05);
        t1 = mk(A_LV, 8'd128, B_C, K03);
      end
      TONE_CANDY: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K06);
            t1 = mk(A_G, 8'd0, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_SR, 8'd77, B_C, K04);
            t1 = mk(A_SB, 8'd51, B_C, K03);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K05);
            t1 = mk(A_SR, 8'd51, B_C, K03);
          end
        endcase
      end
      TONE_LAVA: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd255, B_C, K08);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd60, B_C, K06);
            t1 = mk(A_SR, 8'd51, B_C, K03);
          end
          default: begin
            t0 = mkn(K08);
          end
        endcase
      end
      TONE_ALIEN: begin
        case (ch)
          CH_RED: begin
            t0 = mkn(K04);
            t1 = mk(A_SG, 8'd128, B_C, K04);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd255, B_C, K05);
            t1 = mk(A_C, 8'd0, B_R, K03);
          end
          default: begin
            t0 = mk(A_LV, 8'd180, B_C, K04);
            t1 = mk(A_SG, 8'd77, B_C, K03);
          end
        endcase
      end
      TONE_VINTAGE: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_LV, 8'd210, B_C, K03);
            t1 = mk(A_LV, 8'd128, B_C, K02);
            t2 = mk(A_SG, 8'd26, B_C, K02);
          end
          CH_GRN: begin
            t0 = mk(A_LV, 8'd180, B_C, K03);
            t1 = mk(A_LV, 8'd128, B_C, K02);
          end
          default: begin
            t0 = mk(A_LV, 8'd100, B_C, K04);
            t1 = mk(A_SR, 8'd13, B_C, K02);
          end
        endcase
      end
      TONE_CYBER: begin
        case (ch)
          CH_RED: begin
            t0 = mk(A_CYB, 8'd0, B_ZERO, K06);
            t1 = mk(A_B, 8'd0, B_C, K03);
          end
          CH_GRN: begin
            t0 = mk(A_SB, 8'd128, B_C, K05);
            t1 = mk(A_LV, 8'd255, B_C, K02);
          end
          default: begin
            t0 = mk(A_LV, 8'd255, B_C, K07);
            t1 = mk(A_C, 8'd0, B_R, K03);
          end
        endcase
      end
      default: begin
        // Unassigned tone codes pass the pixel through.
        t0 = z;
      end
    endcase
    case (idx)
      2'd0:    res = t0;
      2'd1:    res = t1;
      2'd2:    res = t2;
      default: res = z;
    endcase
    return res;
  endfunction

endpackage

// ===== src/tgpf_front.sv =====
// ----------------------------------------------------------------------------
// Tone grade pixel filter front end
// Accepts pixels, computes luminance and rough-tone noise, feeds the queue.
// ----------------------------------------------------------------------------
module tgpf_front import tgpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [4:0]  mode_i,
  input  tgpf_qstat_t stat_i,
  output logic        push_o,
  output tgpf_item_t  item_o
);

  logic        f_valid_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;
  logic [4:0]  mode_q;
  logic [31:0] seed_q;
  logic [31:0] seed_d;
  logic        accept;

  logic [23:0] luma_sum;
  logic [6:0]  nib_sum;
  logic [4:0]  fold1;
  logic [4:0]  fold2;
  logic [2:0]  mod5;
  logic [6:0]  mod80;

  assign push_o     = f_valid_q && !stat_i.full;
  assign in_ready_o = !f_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // The xorshift generator steps once for each rough-tone transaction.
  always_comb begin
    seed_d = seed_q;
    if (accept && (mode_i == TONE_ROUGH)) begin
      seed_d = seed_d ^ (seed_d << 13);
      seed_d = seed_d ^ (seed_d >> 17);
      seed_d = seed_d ^ (seed_d << 5);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      seed_q    <= 32'd1;
    end else begin
      seed_q <= seed_d;
      if (accept) begin
        f_valid_q <= 1'b1;
      end else if (push_o) begin
        f_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      mode_q  <= mode_i;
    end
  end

  // Luminance with 16 fraction bits; the item keeps the top 16 bits, 8 fraction bits.
  assign luma_sum = 24'(red_q * 14'd13933) + 24'(green_q * 16'd46871)
                  + 24'(blue_q * 13'd4732);

  // Seed mod 80: low nibble plus 16 times the upper bits mod 5. Since 16 is
  // 1 mod 5, the upper bits reduce by summing their nibbles.
  always_comb begin
    nib_sum = 7'd0;
    for (int i = 0; i < 7; i++) begin
      nib_sum = nib_sum + {3'b000, seed_q[4*i+4 +: 4]};
    end
    fold1 = {2'b00, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
    fold2 = {4'b0000, fold1[4]} + {1'b0, fold1[3:0]};
    if (fold2 >= 5'd15) begin
      mod5 = 3'(fold2 - 5'd15);
    end else if (fold2 >= 5'd10) begin
      mod5 = 3'(fold2 - 5'd10);
    end else if (fold2 >= 5'd5) begin
      mod5 = 3'(fold2 - 5'd5);
    end else begin
      mod5 = fold2[2:0];
    end
    mod80 = {mod5, seed_q[3:0]};
  end

  always_comb begin
    item_o.red   = red_q;
    item_o.green = green_q;
    item_o.blue  = blue_q;
    item_o.luma  = luma_sum[23:8];
    item_o.noise = $signed(mod80 - 7'd40);
    item_o.mode  = mode_q;
  end

endmodule

// ===== src/tgpf_queue.sv =====
// ----------------------------------------------------------------------------
// Tone grade pixel filter queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tgpf_queue import tgpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tgpf_item_t  item_i,
  input  logic        pop_i,
  output tgpf_item_t  item_o,
  output tgpf_qstat_t stat_o
);

  tgpf_item_t slot_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign item_o       = slot_q[rptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== src/tgpf_back.sv =====
// ----------------------------------------------------------------------------
// Tone grade pixel filter back end
// Walks the tone terms of each channel through a shared scaling pipeline.
// ----------------------------------------------------------------------------
module tgpf_back import tgpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tgpf_item_t  item_i,
  input  tgpf_qstat_t stat_i,
  output logic        pop_o,
  input  logic [16:0] sfac_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  logic [1:0] st_q;
  logic [1:0] ch_q;
  logic [1:0] idx_q;
  logic       v0_q;
  logic       v1_q;
  logic       out_valid_q;

  tgpf_item_t cur_q;
  term_t      tm;

  logic [7:0]         own;
  logic [7:0]         mx;
  logic [15:0]        a_scl;
  logic [15:0]        b_scl;
  logic [15:0]        r77;
  logic signed [17:0] opa;
  logic signed [17:0] opb;

  logic signed [17:0] d_q;
  logic [8:0]         k0_q;
  logic               neg0_q;
  logic               inv0_q;
  logic [1:0]         ch0_q;
  logic signed [27:0] pd_q;
  logic               neg1_q;
  logic               inv1_q;
  logic [1:0]         ch1_q;

  logic [16:0]        fac;
  logic signed [45:0] prod;
  logic signed [20:0] fterm;
  logic signed [20:0] acc_q [3];
  logic [7:0]         red_q;
  logic [7:0]         green_q;
  logic [7:0]         blue_q;

  function automatic logic [7:0] clamp8(logic signed [20:0] t);
    logic [7:0] res;
    if (t[20]) begin
      res = 8'd0;
    end else if (t[19:16] != 4'd0) begin
      res = 8'd255;
    end else begin
      res = t[15:8];
    end
    return res;
  endfunction

  assign pop_o       = (st_q == ST_IDLE) && !stat_i.empty && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

  // Sequencer: nine term slots per pixel, then wait for the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ch_q        <= CH_RED;
      idx_q       <= 2'd0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v0_q <= (st_q == ST_ISSUE);
      v1_q <= v0_q;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          ch_q  <= CH_RED;
          idx_q <= 2'd0;
          if (pop_o) begin
            st_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (idx_q == 2'd2) begin
            idx_q <= 2'd0;
            if (ch_q == CH_BLU) begin
              st_q <= ST_FIN;
            end else begin
              ch_q <= ch_q + 2'd1;
            end
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        ST_FIN: begin
          if (!v0_q && !v1_q) begin
            out_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign tm = tone_term(cur_q.mode, ch_q, idx_q);

  // Operand selection for the current term.
  always_comb begin
    case (ch_q)
      CH_RED:  own = cur_q.red;
      CH_GRN:  own = cur_q.green;
      default: own = cur_q.blue;
    endcase
    mx = (cur_q.red > cur_q.green) ? cur_q.red : cur_q.green;
    if (cur_q.blue > mx) begin
      mx = cur_q.blue;
    end
    r77 = {8'd0, cur_q.red} * {8'd0, K03[7:0]};
    case (tm.a)
      A_SR:    a_scl = {8'd0, cur_q.red} * {8'd0, tm.av};
      A_SG:    a_scl = {8'd0, cur_q.green} * {8'd0, tm.av};
      default: a_scl = {8'd0, cur_q.blue} * {8'd0, tm.av};
    endcase
    b_scl = {8'd0, cur_q.blue} * {8'd0, tm.av};

    unique case (tm.a)
      A_C:     opa = $signed({2'b00, own, 8'd0});
      A_R:     opa = $signed({2'b00, cur_q.red, 8'd0});
      A_G:     opa = $signed({2'b00, cur_q.green, 8'd0});
      A_B:     opa = $signed({2'b00, cur_q.blue, 8'd0});
      A_Y:     opa = $signed({2'b00, cur_q.luma});
      A_LV:    opa = $signed({2'b00, tm.av, 8'd0});
      A_SR, A_SG, A_SB: opa = $signed({2'b00, a_scl});
      A_VIB:   opa = (own == mx) ? $signed({2'b00, 8'd255, 8'd0}) : 18'sd0;
      A_NOISE: opa = $signed({{3{cur_q.noise[6]}}, cur_q.noise, 8'd0});
      A_CYB: begin
        // Bright red pulls toward white, otherwise red is pushed down.
        if (cur_q.red > 8'd200) begin
          opa = $signed({2'b00, 8'd255, 8'd0}) - $signed({2'b00, cur_q.red, 8'd0});
        end else begin
          opa = -$signed({2'b00, r77});
        end
      end
      default: opa = 18'sd0;
    endcase

    unique case (tm.b)
      B_C:     opb = $signed({2'b00, own, 8'd0});
      B_R:     opb = $signed({2'b00, cur_q.red, 8'd0});
      B_G:     opb = $signed({2'b00, cur_q.green, 8'd0});
      B_B:     opb = $signed({2'b00, cur_q.blue, 8'd0});
      B_Y:     opb = $signed({2'b00, cur_q.luma});
      B_L128:  opb = $signed({2'b00, 8'd128, 8'd0});
      B_SB:    opb = $signed({2'b00, b_scl});
      default: opb = 18'sd0;
    endcase
  end

  // Stage two of the term pipeline: scale by the strength factor or its
  // complement and keep the floor of the result.
  assign fac   = inv1_q ? 17'(18'd65536 - {1'b0, sfac_i}) : sfac_i;
  assign prod  = pd_q * $signed({1'b0, fac});
  assign fterm = {prod[43], prod[43:24]};

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
      // Noir starts from luminance; every other tone from the channel.
      if (item_i.mode == TONE_NOIR) begin
        acc_q[0] <= $signed({5'd0, item_i.luma});
        acc_q[1] <= $signed({5'd0, item_i.luma});
        acc_q[2] <= $signed({5'd0, item_i.luma});
      end else begin
        acc_q[0] <= $signed({5'd0, item_i.red, 8'd0});
        acc_q[1] <= $signed({5'd0, item_i.green, 8'd0});
        acc_q[2] <= $signed({5'd0, item_i.blue, 8'd0});
      end
    end else if (v1_q) begin
      if (neg1_q) begin
        acc_q[ch1_q] <= acc_q[ch1_q] - fterm;
      end else begin
        acc_q[ch1_q] <= acc_q[ch1_q] + fterm;
      end
    end

    // Stage zero: term difference.
    d_q    <= opa - opb;
    k0_q   <= tm.k;
    neg0_q <= tm.neg;
    inv0_q <= tm.inv;
    ch0_q  <= ch_q;

    // Stage one: weight product.
    pd_q   <= d_q * $signed({1'b0, k0_q});
    neg1_q <= neg0_q;
    inv1_q <= inv0_q;
    ch1_q  <= ch0_q;

    if ((st_q == ST_FIN) && !v0_q && !v1_q) begin
      red_q   <= clamp8(acc_q[0]);
      green_q <= clamp8(acc_q[1]);
      blue_q  <= clamp8(acc_q[2]);
    end
  end

endmodule

// ===== src/tone_grade_pixel_filter_top.sv =====
// An accepted pixel passes the front end register and the queue. The back end
// takes it from the queue, walks nine term steps, and drains its scaling
// pipeline into the output register. It takes the next pixel only after the
// output transaction is done.
// Reset: asynchronous, active low; tone mode and strength clear to zero and the
// noise generator seed returns to one.
// ----------------------------------------------------------------------------
// Tone grade pixel filter top level
// Configuration registers, front end, queue and back end of the tone grader.
// ----------------------------------------------------------------------------
`include "tone_grade_pixel_filter_top_assert.svh"

module tone_grade_pixel_filter_top import tgpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);

  logic [4:0]  mode_q;
  logic [16:0] sfac_q;
  logic [16:0] sfac_d;
  logic [6:0]  pct;
  logic [11:0] rnd_num;
  logic [22:0] rnd_prod;
  logic        cfg_wr;

  logic        push;
  logic        pop;
  tgpf_item_t  f_item;
  tgpf_item_t  q_item;
  tgpf_qstat_t q_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Strength factor in Q1.16: 655 * p + round(0.36 * p), the rounding part
  // taken by a reciprocal multiply that is exact for p up to 100.
  always_comb begin
    pct      = (cfg_data_i[6:0] > 7'd100) ? 7'd100 : cfg_data_i[6:0];
    rnd_num  = 12'(pct * 6'd36) + 12'd50;
    rnd_prod = {11'd0, rnd_num} * 23'd1311;
    sfac_d   = 17'(pct * 10'd655) + {11'd0, rnd_prod[22:17]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= TONE_SOFT;
      sfac_q <= 17'd0;
    end else if (cfg_wr) begin
      if (cfg_index_i == CFG_TONE_MODE) begin
        mode_q <= cfg_data_i[4:0];
      end else if (cfg_index_i == CFG_STRENGTH) begin
        sfac_q <= sfac_d;
      end
    end
  end

  tgpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .mode_i     (mode_q),
    .stat_i     (q_stat),
    .push_o     (push),
    .item_o     (f_item)
  );

  tgpf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  tgpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_item),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .sfac_i      (sfac_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  // Strength factor never exceeds unity.
  `TGPF_ASSERT_IMP(a_sfac_range, 1'b1, sfac_q <= 17'd65536, "strength factor above one")
  // The front end never writes into a full queue.
  `TGPF_ASSERT_IMP(a_no_overflow, push, !q_stat.full, "push into full queue")
  // A push without a pop leaves the queue holding an entry.
  `TGPF_ASSERT_NXT(a_push_fills, push && !pop, !q_stat.empty, "queue lost a transaction")

endmodule
